// ===== hdl/roulette_wheel_selector_top_assert.svh =====
// Assertion macros shared by the selector RTL.
`ifndef ROULETTE_WHEEL_SELECTOR_TOP_ASSERT_SVH
`define ROULETTE_WHEEL_SELECTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rws_pkg.sv =====
package rws_pkg;

  localparam int MAX_GENOMES_DEF  = 256;
  localparam int FITNESS_BITS_DEF = 24;

  // Fixed field widths
  localparam int RAND_BITS = 16;
  localparam int TOTAL_W   = 32;
  localparam int POP_W     = 9;
  localparam int IDX_OUT_W = 8;
  localparam int FIT_IN_W  = 24;

  localparam logic [POP_W-1:0] POP_RESET = 9'd256;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  // Control of the shared accumulate/compare unit
  typedef struct packed {
    logic clear;
    logic acc;
  } walk_ctl_t;

endpackage

// ===== hdl/rws_fit_mem.sv =====
module rws_fit_mem #(
  parameter int DEPTH = rws_pkg::MAX_GENOMES_DEF,
  parameter int WIDTH = rws_pkg::FITNESS_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rws_walk.sv =====
module rws_walk #(
  parameter int MAX_GENOMES  = rws_pkg::MAX_GENOMES_DEF,
  parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF
) (
  input  logic                         clk,
  input  rws_pkg::walk_ctl_t           ctl,
  input  logic [FITNESS_BITS-1:0]      add_val,
  input  logic [rws_pkg::TOTAL_W-1:0]  slice,
  output logic                         hit
);

  localparam int IDX_W = $clog2(MAX_GENOMES);
  localparam int CUM_W = FITNESS_BITS + IDX_W;
  localparam int CMP_W = (CUM_W > rws_pkg::TOTAL_W) ? CUM_W : rws_pkg::TOTAL_W;

  logic [CUM_W-1:0] cum_r;
  logic [CUM_W-1:0] cum_nxt;

  // One adder and one compare, reused for every entry of the walk
  assign cum_nxt = cum_r + CUM_W'(add_val);
  assign hit     = CMP_W'(cum_nxt) > CMP_W'(slice);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      cum_r <= '0;
    end else if (ctl.acc) begin
      cum_r <= cum_nxt;
    end
  end

endmodule

// ===== hdl/roulette_wheel_selector_top.sv =====
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | func, genome_index, fitness_value, random_fraction
// out_    | output    | out_valid/out_stall| selected_index, was_selection
// cfg_    | input     | cfg_valid/cfg_ready| population (9 bits)
//
// A fitness write goes from transfer to result in steps: read the old entry,
// update entry and running total (only for an index in range), then load the output register.
// A selection computes the slice, then walks N entries, N = 0 .. min(population,
// MAX_GENOMES); the single memory read port feeds one entry per cycle.
// After reset a clearing pass zeros every table entry; items wait, cfg does not.
// A stalled result holds in the output register while the next item is taken.
`include "roulette_wheel_selector_top_assert.svh"

module roulette_wheel_selector_top #(
  parameter int MAX_GENOMES  = rws_pkg::MAX_GENOMES_DEF,
  parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // item channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [rws_pkg::IDX_OUT_W-1:0]  in_genome_index,
  input  logic [rws_pkg::FIT_IN_W-1:0]   in_fitness_value,
  input  logic [rws_pkg::RAND_BITS-1:0]  in_random_fraction,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rws_pkg::IDX_OUT_W-1:0]  out_selected_index,
  output logic                           out_was_selection,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rws_pkg::POP_W-1:0]      cfg_data
);

  localparam int IDX_W  = $clog2(MAX_GENOMES);
  localparam int CNT_W  = (IDX_W + 1 > rws_pkg::POP_W) ? IDX_W + 1 : rws_pkg::POP_W;
  localparam int FV_W   = (FITNESS_BITS > rws_pkg::FIT_IN_W) ? FITNESS_BITS
                                                              : rws_pkg::FIT_IN_W;
  localparam int PROD_W = rws_pkg::RAND_BITS + rws_pkg::TOTAL_W;

  localparam logic [FV_W-1:0] FIT_MAX = FV_W'((64'd1 << FITNESS_BITS) - 64'd1);

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WR_RD = 3'd2;
  localparam logic [2:0] S_WR_UP = 3'd3;
  localparam logic [2:0] S_SLICE = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                          state_r, state_nxt;
  logic [rws_pkg::POP_W-1:0]           pop_r;
  logic [rws_pkg::TOTAL_W-1:0]         total_r, total_nxt;
  logic [rws_pkg::TOTAL_W-1:0]         slice_r, slice_nxt;
  logic [IDX_W-1:0]                    clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]                    walk_idx_r, walk_idx_nxt;
  logic [IDX_W-1:0]                    wr_idx_r, wr_idx_nxt;
  logic [FITNESS_BITS-1:0]             fit_r, fit_nxt;
  logic                                inrange_r, inrange_nxt;
  logic [rws_pkg::RAND_BITS-1:0]       u_r, u_nxt;
  logic [rws_pkg::IDX_OUT_W-1:0]       res_idx_r, res_idx_nxt;
  logic                                res_sel_r, res_sel_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [rws_pkg::IDX_OUT_W-1:0]       out_idx_r, out_idx_nxt;
  logic                                out_sel_r, out_sel_nxt;

  logic                                in_xfer;
  logic                                out_free;
  logic [FV_W-1:0]                     fv_ext;
  logic [FV_W-1:0]                     fv_sat;
  logic [CNT_W-1:0]                    gidx_ext;
  logic [CNT_W-1:0]                    walk_cnt;
  logic                                walk_last;
  logic [PROD_W-1:0]                   prod;

  logic                                mem_we;
  logic [IDX_W-1:0]                    mem_waddr;
  logic [FITNESS_BITS-1:0]             mem_wdata;
  logic [IDX_W-1:0]                    mem_raddr;
  logic [FITNESS_BITS-1:0]             mem_rdata;

  rws_pkg::walk_ctl_t                  walk_ctl;
  logic                                walk_hit;

  rws_fit_mem #(
    .DEPTH (MAX_GENOMES),
    .WIDTH (FITNESS_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rws_walk #(
    .MAX_GENOMES  (MAX_GENOMES),
    .FITNESS_BITS (FITNESS_BITS)
  ) u_walk (
    .clk     (clk),
    .ctl     (walk_ctl),
    .add_val (mem_rdata),
    .slice   (slice_r),
    .hit     (walk_hit)
  );

  // Handshakes: items only in idle, configuration always
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_selected_index = out_idx_r;
  assign out_was_selection  = out_sel_r;

  // Saturate incoming fitness to the table width
  assign fv_ext   = FV_W'(in_fitness_value);
  assign fv_sat   = (fv_ext > FIT_MAX) ? FIT_MAX : fv_ext;
  assign gidx_ext = CNT_W'(in_genome_index);

  // Walk bound: stop at min(population, MAX_GENOMES)
  assign walk_cnt  = CNT_W'(walk_idx_r) + CNT_W'(1);
  assign walk_last = (walk_cnt >= CNT_W'(pop_r)) || (walk_cnt >= CNT_W'(MAX_GENOMES));

  assign prod = PROD_W'(u_r) * PROD_W'(total_r);

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    slice_nxt     = slice_r;
    clr_idx_nxt   = clr_idx_r;
    walk_idx_nxt  = walk_idx_r;
    wr_idx_nxt    = wr_idx_r;
    fit_nxt       = fit_r;
    inrange_nxt   = inrange_r;
    u_nxt         = u_r;
    res_idx_nxt   = res_idx_r;
    res_sel_nxt   = res_sel_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_sel_nxt   = out_sel_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_idx_r;
    mem_wdata     = fit_r;
    mem_raddr     = wr_idx_r;
    walk_ctl      = '0;

    // drop a result once the consumer takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = '0;
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (CNT_W'(clr_idx_r) == CNT_W'(MAX_GENOMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          res_idx_nxt = in_genome_index;
          u_nxt       = in_random_fraction;
          wr_idx_nxt  = IDX_W'(in_genome_index);
          fit_nxt     = FITNESS_BITS'(fv_sat);
          inrange_nxt = (gidx_ext < CNT_W'(pop_r)) && (gidx_ext < CNT_W'(MAX_GENOMES));
          if (in_func == rws_pkg::FUNC_SELECT) begin
            res_sel_nxt = 1'b1;
            state_nxt   = S_SLICE;
          end else begin
            res_sel_nxt = 1'b0;
            state_nxt   = S_WR_RD;
          end
        end
      end
      S_WR_RD: begin
        // fetch the old entry so the total can be corrected
        mem_raddr = wr_idx_r;
        state_nxt = S_WR_UP;
      end
      S_WR_UP: begin
        if (inrange_r) begin
          mem_we    = 1'b1;
          total_nxt = total_r - rws_pkg::TOTAL_W'(mem_rdata)
                              + rws_pkg::TOTAL_W'(fit_r);
        end
        state_nxt = S_DONE;
      end
      S_SLICE: begin
        slice_nxt      = prod[rws_pkg::RAND_BITS +: rws_pkg::TOTAL_W];
        walk_ctl.clear = 1'b1;
        walk_idx_nxt   = '0;
        mem_raddr      = '0;
        if (pop_r == '0) begin
          res_idx_nxt = '0;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // one entry per cycle through the shared accumulate/compare unit
        walk_ctl.acc = 1'b1;
        mem_raddr    = walk_idx_r + IDX_W'(1);
        if (walk_hit) begin
          res_idx_nxt = rws_pkg::IDX_OUT_W'(walk_idx_r);
          state_nxt   = S_DONE;
        end else if (walk_last) begin
          res_idx_nxt = '0;
          state_nxt   = S_DONE;
        end else begin
          walk_idx_nxt = walk_idx_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        // hold until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_sel_nxt   = res_sel_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      total_r     <= '0;
      pop_r       <= rws_pkg::POP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        pop_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    slice_r    <= slice_nxt;
    walk_idx_r <= walk_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    fit_r      <= fit_nxt;
    inrange_r  <= inrange_nxt;
    u_r        <= u_nxt;
    res_idx_r  <= res_idx_nxt;
    res_sel_r  <= res_sel_nxt;
    out_idx_r  <= out_idx_nxt;
    out_sel_r  <= out_sel_nxt;
  end

  `RWS_ASSERT_NEXT(a_busy_after_xfer, in_xfer, in_stall, "item transfer did not start work")
  `RWS_ASSERT_NOW(a_load_from_done, $rose(out_valid_r), $past(state_r) == S_DONE,
                  "result loaded outside done state")
  `RWS_ASSERT_NOW(a_walk_bound, state_r == S_WALK,
                  (CNT_W'(walk_idx_r) < CNT_W'(pop_r)) &&
                  (CNT_W'(walk_idx_r) < CNT_W'(MAX_GENOMES)),
                  "walk ran past the population bound")

endmodule
